FILE: rtl/bdpc_pkg.sv
// Package with shared types and constants for the button debounce press classifier.
package bdpc_pkg;

	// Configuration register indexes.
	localparam int unsigned CfgIndexWidth = 2;
	localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE_MS = 2'd0;
	localparam logic [CfgIndexWidth-1:0] REG_LONG_MS     = 2'd1;

	// Configuration reset values.
	localparam logic [15:0] DEBOUNCE_MS_RESET = 16'd20;
	localparam logic [15:0] LONG_MS_RESET     = 16'd700;

	// Press event codes.
	localparam logic [1:0] EVT_NONE  = 2'd0;
	localparam logic [1:0] EVT_SHORT = 2'd1;
	localparam logic [1:0] EVT_LONG  = 2'd2;

	// Input word: one button sample.
	typedef struct packed {
		logic        raw_pressed;
		logic [31:0] now_ms;
	} in_word_t;

	// Output word: one classification result.
	typedef struct packed {
		logic [1:0] press_event;
		logic       is_down;
	} out_word_t;

endpackage

FILE: rtl/button_debounce_press_classifier_unit.sv
// Top level of the button debounce and short/long press classifier.
// A word passes the input register, then the result register; one word per
// cycle unless out_stall holds a full result register. The input register
// feeds one pass of two subtract-and-compare paths writing result and state.
// Reset: arst_n clears all control state and the configuration returns to
// debounce 20 ms and long press 700 ms.
module button_debounce_press_classifier_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  bdpc_pkg::in_word_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bdpc_pkg::out_word_t                out_data,
	input  logic                               cfg_we,
	input  logic [bdpc_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [15:0]                        cfg_wdata
);

	// Configuration registers.
	logic [15:0] debounce_ms_q;
	logic [15:0] long_ms_q;

	// Classifier state.
	logic        debounced_down_q;
	logic        raw_previous_q;
	logic [31:0] last_edge_time_q;
	logic [31:0] press_start_time_q;
	logic        long_emitted_q;

	// Input stage.
	logic               valid_s1;
	bdpc_pkg::in_word_t data_s1;

	// Result register.
	logic                valid_q;
	bdpc_pkg::out_word_t result_q;

	// Next-state logic.
	logic        advance;
	logic        raw_edge;
	logic [31:0] edge_time;
	logic [31:0] stable_time;
	logic [31:0] held_time;
	logic        level;
	logic        press_start;
	logic        long_fire;
	logic        release_seen;
	logic [1:0]  press_event;

	// The input stage moves on whenever the result register is free or drained.
	assign advance  = !valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Debounce: time since the last raw edge decides whether the raw level counts.
	always_comb begin
		raw_edge    = data_s1.raw_pressed != raw_previous_q;
		edge_time   = raw_edge ? data_s1.now_ms : last_edge_time_q;
		stable_time = data_s1.now_ms - edge_time;
		level       = (stable_time >= {16'd0, debounce_ms_q}) ? data_s1.raw_pressed
			: debounced_down_q;
	end

	// Press classification on the debounced level.
	always_comb begin
		held_time    = data_s1.now_ms - press_start_time_q;
		press_start  = level && !debounced_down_q;
		long_fire    = level && debounced_down_q && !long_emitted_q
			&& (held_time >= {16'd0, long_ms_q});
		release_seen = !level && debounced_down_q;
		press_event  = bdpc_pkg::EVT_NONE;
		if (long_fire) begin
			press_event = bdpc_pkg::EVT_LONG;
		end else if (release_seen && !long_emitted_q) begin
			press_event = bdpc_pkg::EVT_SHORT;
		end
	end

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= bdpc_pkg::DEBOUNCE_MS_RESET;
			long_ms_q     <= bdpc_pkg::LONG_MS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bdpc_pkg::REG_DEBOUNCE_MS) begin
				debounce_ms_q <= cfg_wdata;
			end else if (cfg_index == bdpc_pkg::REG_LONG_MS) begin
				long_ms_q <= cfg_wdata;
			end
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// State and result valid update when a word leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounced_down_q   <= 1'b0;
			raw_previous_q     <= 1'b0;
			last_edge_time_q   <= 32'd0;
			press_start_time_q <= 32'd0;
			long_emitted_q     <= 1'b0;
			valid_q            <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
			if (valid_s1) begin
				raw_previous_q   <= data_s1.raw_pressed;
				last_edge_time_q <= edge_time;
				debounced_down_q <= level;
				if (press_start) begin
					press_start_time_q <= data_s1.now_ms;
					long_emitted_q     <= 1'b0;
				end else if (long_fire) begin
					long_emitted_q <= 1'b1;
				end
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q.press_event <= press_event;
			result_q.is_down     <= level;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = result_q;

endmodule

FILE: rtl/bdpc_checker.sv
// Port-level checker for the button debounce press classifier, with its bind.
module bdpc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input bdpc_pkg::out_word_t out_data
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	// No result is shown while reset is held.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// A long event only happens while the button is held.
	a_long_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.press_event == bdpc_pkg::EVT_LONG |-> out_data.is_down)
		else $error("long event with button released");

	// A short event only happens on release.
	a_short_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.press_event == bdpc_pkg::EVT_SHORT |-> !out_data.is_down)
		else $error("short event with button held");

	// Event code stays within the defined set.
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.press_event == bdpc_pkg::EVT_NONE
			|| out_data.press_event == bdpc_pkg::EVT_SHORT
			|| out_data.press_event == bdpc_pkg::EVT_LONG)
		else $error("undefined event code");

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (.*);
